### design/sdf_pkg.sv
package sdf_pkg;

    // Register indexes on the configuration channel
    localparam logic [7:0] REG_STIFFNESS = 8'd0;
    localparam logic [7:0] REG_DAMPING   = 8'd1;

    localparam logic [31:0] STIFFNESS_RESET = 32'd65536;
    localparam logic [31:0] DAMPING_RESET   = 32'd58982;

    // Square root: 34 result bits out of a 68-bit radicand
    localparam int ROOT_W = 34;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 4;

    // Direction: quotient bits 30 down to 0, remainder below the length
    localparam int Q_W    = 31;
    localparam int DREM_W = ROOT_W + 1;
    localparam int DIV_TOP = Q_W - 1;

    // Per-spring values carried alongside the iterative cells
    typedef struct packed {
        logic [32:0]        dxm;
        logic [32:0]        dym;
        logic               dx_neg;
        logic               dy_neg;
        logic signed [32:0] vrx;
        logic signed [32:0] vry;
        logic [31:0]        rest;
        logic               degen;
    } item_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [ROOT_W-1:0] len;
        logic [DREM_W-1:0] remx;
        logic [DREM_W-1:0] remy;
        logic [Q_W-1:0]    qx;
        logic [Q_W-1:0]    qy;
    } quot_t;

    // Stage control handed to every cell
    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

endpackage

### design/spring_damper_force_2d.sv
// Damped spring force in 2D, one spring per stream transaction.
// Input channel s_*: both positions, both velocities and the rest length,
// signed Q16.16 (rest length unsigned). Output channel m_*: the force on the
// first point in Q16.16, saturated to 32 bits, and a flag in m_tuser that
// marks coincident points, for which the force is zero. The second point
// takes the negated force.
// Configuration channel cfg_*: index 0 writes the stiffness, index 1 the
// damping coefficient (unsigned Q16.16); other indexes are dropped. cfg_ready
// is always high; write only while no spring is in flight.
// The pipeline has three front-end stages, a row of 34 square-root cells
// (one root bit each), a row of 31 divider cells (one direction bit per
// axis each) and eight multiply, add and saturate stages ending in the
// output register.
// Throughput is one spring per cycle. The whole pipeline advances together;
// when m_tready is low with a result held, s_tready drops and every stage
// holds until the result is taken.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// register defaults 1.0 and 0.9.
module spring_damper_force_2d import sdf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // first_x, first_y, second_x, second_y, first_vx, first_vy,
    // second_vx, second_vy, rest_length
    input  logic [287:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // force_x, force_y
    output logic [63:0]  m_tdata,
    // degenerate
    output logic [0:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int NSQ  = ROOT_W;
    localparam int NDIV = Q_W;

    logic en;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Configuration registers
    logic [31:0] stiff_reg;
    logic [31:0] damp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg <= STIFFNESS_RESET;
            damp_reg  <= DAMPING_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_STIFFNESS: stiff_reg <= cfg_data;
                REG_DAMPING:   damp_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: differences, squares, sum
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    item_t              in_item;

    always_comb begin
        dx = $signed({s_tdata[95], s_tdata[95:64]}) - $signed({s_tdata[31], s_tdata[31:0]});
        dy = $signed({s_tdata[127], s_tdata[127:96]})
           - $signed({s_tdata[63], s_tdata[63:32]});
        in_item.dx_neg = dx[32];
        in_item.dy_neg = dy[32];
        in_item.dxm    = dx[32] ? 33'(-dx) : 33'(dx);
        in_item.dym    = dy[32] ? 33'(-dy) : 33'(dy);
        in_item.vrx    = $signed({s_tdata[223], s_tdata[223:192]})
                       - $signed({s_tdata[159], s_tdata[159:128]});
        in_item.vry    = $signed({s_tdata[255], s_tdata[255:224]})
                       - $signed({s_tdata[191], s_tdata[191:160]});
        in_item.rest   = s_tdata[287:256];
        in_item.degen  = 1'b0;
    end

    logic        v0_reg, v1_reg, v2_reg;
    item_t       it0_reg, it1_reg, it2_reg;
    item_t       it1_deg;
    logic [65:0] sqx_reg, sqy_reg;
    logic [66:0] sq_sum;
    logic [66:0] sq_reg;

    assign sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Mark coincident points on the payload
    always_comb begin
        it1_deg       = it1_reg;
        it1_deg.degen = (sq_sum == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it0_reg       <= in_item;
            it1_reg       <= it0_reg;
            sqx_reg       <= it0_reg.dxm * it0_reg.dxm;
            sqy_reg       <= it0_reg.dym * it0_reg.dym;
            it2_reg       <= it1_deg;
            sq_reg        <= sq_sum;
        end
    end

    // Row of square-root cells, most significant root bit first
    logic  sq_v   [0:NSQ];
    item_t sq_it  [0:NSQ];
    sqrt_t sq_st  [0:NSQ];

    assign sq_v[0]       = v2_reg;
    assign sq_it[0]      = it2_reg;
    assign sq_st[0].rad  = {{(RAD_W-67){1'b0}}, sq_reg};
    assign sq_st[0].rem  = '0;
    assign sq_st[0].root = '0;

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        stage_ctl_t ctl;
        assign ctl.en    = en;
        assign ctl.valid = sq_v[g];
        sdf_sqrt_cell #(.BIT(NSQ - 1 - g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_ctl    (ctl),
            .in_item   (sq_it[g]),
            .in_sq     (sq_st[g]),
            .out_valid (sq_v[g+1]),
            .out_item  (sq_it[g+1]),
            .out_sq    (sq_st[g+1])
        );
    end

    // Row of divider cells for the unit direction
    logic  dv_v  [0:NDIV];
    item_t dv_it [0:NDIV];
    quot_t dv_q  [0:NDIV];

    assign dv_v[0]      = sq_v[NSQ];
    assign dv_it[0]     = sq_it[NSQ];
    assign dv_q[0].len  = sq_st[NSQ].root;
    assign dv_q[0].remx = {{(DREM_W-32){1'b0}}, sq_it[NSQ].dxm[32:1]};
    assign dv_q[0].remy = {{(DREM_W-32){1'b0}}, sq_it[NSQ].dym[32:1]};
    assign dv_q[0].qx   = '0;
    assign dv_q[0].qy   = '0;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        stage_ctl_t ctl;
        assign ctl.en    = en;
        assign ctl.valid = dv_v[g];
        sdf_div_cell #(.BIT(DIV_TOP - g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_ctl    (ctl),
            .in_item   (dv_it[g]),
            .in_q      (dv_q[g]),
            .out_valid (dv_v[g+1]),
            .out_item  (dv_it[g+1]),
            .out_q     (dv_q[g+1])
        );
    end

    // Back end: projection, scalar force, component products, saturation
    item_t              bi;
    quot_t              bq;
    logic signed [31:0] nx;
    logic signed [31:0] ny;

    assign bi = dv_it[NDIV];
    assign bq = dv_q[NDIV];
    assign nx = bi.dx_neg ? -$signed({1'b0, bq.qx}) : $signed({1'b0, bq.qx});
    assign ny = bi.dy_neg ? -$signed({1'b0, bq.qy}) : $signed({1'b0, bq.qy});

    logic [7:1] bv_reg;
    logic [7:1] degen_reg;
    logic [7:1] xneg_reg;
    logic [7:1] yneg_reg;
    logic [Q_W-1:0]    qx_reg [1:7];
    logic [Q_W-1:0]    qy_reg [1:7];
    logic [ROOT_W-1:0] len_reg [1:3];
    logic [31:0]       rest_reg [1:3];

    logic signed [64:0] px_reg, py_reg;
    logic signed [65:0] dot_reg;
    logic signed [36:0] vdot_reg;
    logic signed [34:0] stretch_reg;
    logic signed [67:0] fa_reg;
    logic signed [69:0] fb_reg;
    logic signed [70:0] s_reg;
    logic [69:0]        smag_reg;
    logic [65:0]        plx_reg, phx_reg, ply_reg, phy_reg;

    logic [65:0]        dot_abs;
    logic [35:0]        dmag;
    logic signed [36:0] vdot;
    logic signed [34:0] stretch;
    logic [69:0]        smag;

    always_comb begin
        dot_abs = dot_reg[65] ? 66'(-dot_reg) : 66'(dot_reg);
        dmag    = dot_abs[65:30];
        vdot    = dot_reg[65] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
        stretch = $signed({1'b0, len_reg[2]}) - $signed({3'b000, rest_reg[2]});
        smag    = s_reg[70] ? 70'(-s_reg) : 70'(s_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= '0;
        end else if (en) begin
            bv_reg <= {bv_reg[6:1], dv_v[NDIV]};
        end
    end

    // Advance the back-end payload
    always_ff @(posedge aclk) begin
        if (en) begin
            degen_reg   <= {degen_reg[6:1], bi.degen};
            qx_reg[1]   <= bq.qx;
            qy_reg[1]   <= bq.qy;
            len_reg[1]  <= bq.len;
            rest_reg[1] <= bi.rest;
            for (int i = 2; i <= 7; i++) begin
                qx_reg[i] <= qx_reg[i-1];
                qy_reg[i] <= qy_reg[i-1];
            end
            for (int i = 2; i <= 3; i++) begin
                len_reg[i]  <= len_reg[i-1];
                rest_reg[i] <= rest_reg[i-1];
            end
            xneg_reg <= {xneg_reg[6], xneg_reg[5] ^ s_reg[70], xneg_reg[4:1], bi.dx_neg};
            yneg_reg <= {yneg_reg[6], yneg_reg[5] ^ s_reg[70], yneg_reg[4:1], bi.dy_neg};

            px_reg      <= bi.vrx * nx;
            py_reg      <= bi.vry * ny;
            dot_reg     <= px_reg + py_reg;
            vdot_reg    <= vdot;
            stretch_reg <= stretch;
            fa_reg      <= $signed({1'b0, stiff_reg}) * stretch_reg;
            fb_reg      <= $signed({1'b0, damp_reg}) * vdot_reg;
            s_reg       <= fa_reg + fb_reg;
            smag_reg    <= smag;
            plx_reg     <= smag_reg[34:0] * qx_reg[6];
            phx_reg     <= smag_reg[69:35] * qx_reg[6];
            ply_reg     <= smag_reg[34:0] * qy_reg[6];
            phy_reg     <= smag_reg[69:35] * qy_reg[6];
        end
    end

    // Combine partial products, drop 46 fraction bits, saturate
    function automatic logic [31:0] sat_force(input logic [100:0] prod, input logic neg);
        logic [54:0] m;
        m = prod[100:46];
        if (neg) begin
            sat_force = (m >= 55'h8000_0000) ? 32'h8000_0000 : 32'(-m[31:0]);
        end else begin
            sat_force = (m > 55'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        end
    endfunction

    logic [100:0] prodx;
    logic [100:0] prody;
    assign prodx = {phx_reg, 35'b0} + {35'b0, plx_reg};
    assign prody = {phy_reg, 35'b0} + {35'b0, ply_reg};

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic        out_degen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= bv_reg[7];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_degen_reg <= degen_reg[7];
            if (degen_reg[7]) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg <= {sat_force(prody, yneg_reg[7]), sat_force(prodx, xneg_reg[7])};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_degen_reg;

endmodule

### design/sdf_sqrt_cell.sv
module sdf_sqrt_cell import sdf_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  stage_ctl_t in_ctl,
    input  item_t      in_item,
    input  sqrt_t      in_sq,
    output logic       out_valid,
    output item_t      out_item,
    output sqrt_t      out_sq
);

    logic              valid_reg;
    item_t             item_reg;
    sqrt_t             sq_reg;
    sqrt_t             sq_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // Bring down two radicand bits and try one more root bit
    always_comb begin
        rem_sh = {in_sq.rem[REM_W-3:0], in_sq.rad[2*BIT+1 -: 2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, in_sq.root, 2'b01};
        ge     = (rem_sh >= trial);
        sq_next.rad  = in_sq.rad;
        sq_next.rem  = ge ? (rem_sh - trial) : rem_sh;
        sq_next.root = {in_sq.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ctl.en) begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ctl.en) begin
            item_reg <= in_item;
            sq_reg   <= sq_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_sq    = sq_reg;

endmodule

### design/sdf_div_cell.sv
module sdf_div_cell import sdf_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  stage_ctl_t in_ctl,
    input  item_t      in_item,
    input  quot_t      in_q,
    output logic       out_valid,
    output item_t      out_item,
    output quot_t      out_q
);

    localparam bit TOP_CELL = (BIT == DIV_TOP);

    logic              valid_reg;
    item_t             item_reg;
    quot_t             q_reg;
    quot_t             q_next;
    logic [DREM_W-1:0] rsx;
    logic [DREM_W-1:0] rsy;
    logic [DREM_W-1:0] den;
    logic              gex;
    logic              gey;
    logic              bx;
    logic              by;

    // One quotient bit for each axis; only the top cell shifts in a dividend bit
    always_comb begin
        bx  = TOP_CELL ? in_item.dxm[0] : 1'b0;
        by  = TOP_CELL ? in_item.dym[0] : 1'b0;
        rsx = {in_q.remx[DREM_W-2:0], bx};
        rsy = {in_q.remy[DREM_W-2:0], by};
        den = {1'b0, in_q.len};
        gex = (rsx >= den);
        gey = (rsy >= den);
        q_next.len  = in_q.len;
        q_next.remx = gex ? (rsx - den) : rsx;
        q_next.remy = gey ? (rsy - den) : rsy;
        q_next.qx   = {in_q.qx[Q_W-2:0], gex};
        q_next.qy   = {in_q.qy[Q_W-2:0], gey};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ctl.en) begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ctl.en) begin
            item_reg <= in_item;
            q_reg    <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_q     = q_reg;

endmodule

### design/sdf_checker.sv
module sdf_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic [63:0]  m_tdata,
    input logic [0:0]   m_tuser,
    input logic         m_tvalid,
    input logic         m_tready
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input side advances exactly when the output register can take data
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready out of step with output stall");

    // Coincident points give zero force
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
        else $error("degenerate spring with nonzero force");

    // Reset leaves no result valid at the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind spring_damper_force_2d sdf_checker u_sdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
